// ===== hw/rtl/tlf_pkg.sv =====
// Shared types, constants and helper functions for the two-road traffic light controller.
package tlf_pkg;

  localparam int unsigned CountW = 7;
  localparam int unsigned DigitW = 4;
  localparam int unsigned NumRegs = 7;
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  localparam logic [CountW-1:0] CountMax = 7'd99;

  localparam logic [2:0] RegPhaseAStart = 3'd0;
  localparam logic [2:0] RegPhaseAYellow = 3'd1;
  localparam logic [2:0] RegPhaseBStart = 3'd2;
  localparam logic [2:0] RegPhaseBYellow = 3'd3;
  localparam logic [2:0] RegTransStart = 3'd4;
  localparam logic [2:0] RegSouthStart = 3'd5;
  localparam logic [2:0] RegWestStart = 3'd6;

  localparam logic [CountW-1:0] RstPhaseAStart = 7'd23;
  localparam logic [CountW-1:0] RstPhaseAYellow = 7'd20;
  localparam logic [CountW-1:0] RstPhaseBStart = 7'd15;
  localparam logic [CountW-1:0] RstPhaseBYellow = 7'd12;
  localparam logic [CountW-1:0] RstTransStart = 7'd3;
  localparam logic [CountW-1:0] RstSouthStart = 7'd15;
  localparam logic [CountW-1:0] RstWestStart = 7'd23;

  // Reciprocal of ten scaled by 2**11, exact for values up to 179.
  localparam logic [7:0] RecipTen = 8'd205;
  localparam int unsigned RecipShift = 11;
  localparam logic [3:0] Ten = 4'd10;

  typedef struct packed {
    logic [CountW-1:0] phase_a_start;
    logic [CountW-1:0] phase_a_yellow_limit;
    logic [CountW-1:0] phase_b_start;
    logic [CountW-1:0] phase_b_yellow_limit;
    logic [CountW-1:0] transition_start;
    logic [CountW-1:0] south_green_start;
    logic [CountW-1:0] west_green_start;
  } cfg_t;

  typedef struct packed {
    logic road_one_red;
    logic road_one_yellow;
    logic road_one_green;
    logic road_two_red;
    logic road_two_yellow;
    logic road_two_green;
    logic [DigitW-1:0] tens_digit;
    logic [DigitW-1:0] units_digit;
  } res_t;

  function automatic logic [CountW-1:0] clamp99(input logic [CountW-1:0] v);
    clamp99 = (v > CountMax) ? CountMax : v;
  endfunction

  function automatic logic [DigitW-1:0] tens_of(input logic [CountW-1:0] v);
    logic [14:0] prod;
    prod = 15'(v) * 15'(RecipTen);
    tens_of = prod[14:RecipShift];
  endfunction

  function automatic logic [DigitW-1:0] units_of(input logic [CountW-1:0] v,
                                                 input logic [DigitW-1:0] t);
    logic [CountW-1:0] sub;
    sub = 7'(t) * 7'(Ten);
    units_of = DigitW'(v - sub);
  endfunction

endpackage

// ===== hw/rtl/tlf_cfg_regs.sv =====
// Configuration register file with an APB-style access port.
module tlf_cfg_regs
  import tlf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t cfg_q;
  logic [2:0] idx;
  logic wr_en;
  logic [CountW-1:0] wval;
  logic [CountW-1:0] rval;

  assign pready = 1'b1;
  assign idx = paddr[4:2];
  assign wr_en = psel && penable && pwrite;
  assign wval = pwdata[CountW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_a_start <= RstPhaseAStart;
      cfg_q.phase_a_yellow_limit <= RstPhaseAYellow;
      cfg_q.phase_b_start <= RstPhaseBStart;
      cfg_q.phase_b_yellow_limit <= RstPhaseBYellow;
      cfg_q.transition_start <= RstTransStart;
      cfg_q.south_green_start <= RstSouthStart;
      cfg_q.west_green_start <= RstWestStart;
    end else if (wr_en) begin
      unique case (idx)
        RegPhaseAStart:  cfg_q.phase_a_start <= wval;
        RegPhaseAYellow: cfg_q.phase_a_yellow_limit <= wval;
        RegPhaseBStart:  cfg_q.phase_b_start <= wval;
        RegPhaseBYellow: cfg_q.phase_b_yellow_limit <= wval;
        RegTransStart:   cfg_q.transition_start <= wval;
        RegSouthStart:   cfg_q.south_green_start <= wval;
        RegWestStart:    cfg_q.west_green_start <= wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegPhaseAStart:  rval = cfg_q.phase_a_start;
      RegPhaseAYellow: rval = cfg_q.phase_a_yellow_limit;
      RegPhaseBStart:  rval = cfg_q.phase_b_start;
      RegPhaseBYellow: rval = cfg_q.phase_b_yellow_limit;
      RegTransStart:   rval = cfg_q.transition_start;
      RegSouthStart:   rval = cfg_q.south_green_start;
      RegWestStart:    rval = cfg_q.west_green_start;
      default:         rval = '0;
    endcase
  end

  assign prdata = DataW'(rval);
  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/tlf_step.sv =====
// Phase state machine that turns one tick into the lamp pattern and countdown digits.
module tlf_step
  import tlf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic advance_i,
  input  logic manual_request_i,
  input  logic manual_direction_i,
  input  cfg_t cfg_i,
  output res_t res_o
);

  typedef enum logic [1:0] {
    PhA,
    PhB,
    PhTrans,
    PhGreen
  } phase_e;

  phase_e phase_q, phase_d, ph;
  logic [CountW-1:0] count_q, count_d, cnt, start_val;
  logic dir_q, dir_d, dir;
  logic started_q, started_d, st;

  always_comb begin
    ph = phase_q;
    dir = dir_q;
    st = started_q;
    if ((phase_q == PhA || phase_q == PhB) && manual_request_i) begin
      ph = PhTrans;
      dir = manual_direction_i;
      st = 1'b0;
    end else if (phase_q == PhGreen && !manual_request_i) begin
      ph = PhA;
      st = 1'b0;
    end

    unique case (ph)
      PhA:     start_val = cfg_i.phase_a_start;
      PhB:     start_val = cfg_i.phase_b_start;
      PhTrans: start_val = cfg_i.transition_start;
      default: start_val = dir ? cfg_i.west_green_start : cfg_i.south_green_start;
    endcase
    cnt = st ? count_q : clamp99(start_val);

    res_o = '0;
    unique case (ph)
      PhA: begin
        if (cnt > cfg_i.phase_a_yellow_limit) begin
          res_o.road_one_yellow = 1'b1;
        end else begin
          res_o.road_one_green = 1'b1;
        end
        res_o.road_two_red = 1'b1;
      end
      PhB: begin
        res_o.road_one_red = 1'b1;
        if (cnt > cfg_i.phase_b_yellow_limit) begin
          res_o.road_two_yellow = 1'b1;
        end else begin
          res_o.road_two_green = 1'b1;
        end
      end
      PhTrans: begin
        res_o.road_one_yellow = 1'b1;
        res_o.road_two_yellow = 1'b1;
      end
      default: begin
        if (dir) begin
          res_o.road_one_green = 1'b1;
          res_o.road_two_red = 1'b1;
        end else begin
          res_o.road_one_red = 1'b1;
          res_o.road_two_green = 1'b1;
        end
      end
    endcase
    res_o.tens_digit = tens_of(cnt);
    res_o.units_digit = units_of(cnt, res_o.tens_digit);

    dir_d = dir;
    if (cnt == '0) begin
      unique case (ph)
        PhA:     phase_d = PhB;
        PhB:     phase_d = PhA;
        PhTrans: phase_d = PhGreen;
        default: phase_d = PhA;
      endcase
      count_d = cnt;
      started_d = 1'b0;
    end else begin
      phase_d = ph;
      count_d = cnt - 1'b1;
      started_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhA;
      count_q <= RstPhaseAStart;
      dir_q <= 1'b0;
      started_q <= 1'b0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      dir_q <= dir_d;
      started_q <= started_d;
    end
  end

endmodule

// ===== hw/rtl/two_road_traffic_light_fsm_core.sv =====
// Top level of the two-road traffic light controller: input register, step logic, result register.
//
//   Channel  Direction  Handshake                  Payload
//   in       in         in_valid_i / in_ready_o    manual_request_i, manual_direction_i
//   out      out        out_valid_o / out_ready_i  six lamps, tens_digit_o, units_digit_o
//   cfg      in         psel, penable, pready      paddr, pwdata, prdata
//
// Each tick beat passes through the input register and then the result register, and one
// beat can be accepted every cycle while the output is not stalled; the phase state updates
// as a beat moves from the input register into the result register. Reset loads the
// register defaults and starts phase A. When the output stalls, the result register and
// then the input register hold their beats and in_ready_o falls.
module two_road_traffic_light_fsm_core
  import tlf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             manual_request_i,
  input  logic             manual_direction_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             road_one_red_o,
  output logic             road_one_yellow_o,
  output logic             road_one_green_o,
  output logic             road_two_red_o,
  output logic             road_two_yellow_o,
  output logic             road_two_green_o,
  output logic [DigitW-1:0] tens_digit_o,
  output logic [DigitW-1:0] units_digit_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  cfg_t cfg;
  res_t res, res_q;
  logic in_valid_q, req_q, dir_q, out_valid_q, advance;

  assign advance = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= manual_request_i;
      dir_q <= manual_direction_i;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  tlf_cfg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tlf_step u_step (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .advance_i          (advance),
    .manual_request_i   (req_q),
    .manual_direction_i (dir_q),
    .cfg_i              (cfg),
    .res_o              (res)
  );

  assign out_valid_o = out_valid_q;
  assign road_one_red_o = res_q.road_one_red;
  assign road_one_yellow_o = res_q.road_one_yellow;
  assign road_one_green_o = res_q.road_one_green;
  assign road_two_red_o = res_q.road_two_red;
  assign road_two_yellow_o = res_q.road_two_yellow;
  assign road_two_green_o = res_q.road_two_green;
  assign tens_digit_o = res_q.tens_digit;
  assign units_digit_o = res_q.units_digit;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the two-road traffic light controller, with its own lamp predictor.
module testbench;
  import tlf_pkg::*;

  typedef enum logic [1:0] {
    PhRoadOne,
    PhRoadTwo,
    PhTransition,
    PhManualGreen
  } light_phase_e;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned LongHold = 200;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned IgnoredReg = NumRegs;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic manual_request_i = 1'b0;
  logic manual_direction_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic road_one_red_o;
  logic road_one_yellow_o;
  logic road_one_green_o;
  logic road_two_red_o;
  logic road_two_yellow_o;
  logic road_two_green_o;
  logic [DigitW-1:0] tens_digit_o;
  logic [DigitW-1:0] units_digit_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic pready;

  two_road_traffic_light_fsm_core dut (.*);

  // Predictor state.
  logic [CountW-1:0] timing_reg [NumRegs];
  light_phase_e light_phase;
  logic [CountW-1:0] countdown;
  logic held_direction;
  logic countdown_loaded;

  res_t lamp_queue [$];
  int unsigned mismatches = 0;
  int unsigned beats_seen = 0;
  int unsigned cycles = 0;
  bit idling_on = 1'b1;
  bit long_hold_req = 1'b0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (!idling_on) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 0;
    end else if (roll < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic void reset_predictor();
    timing_reg[RegPhaseAStart] = RstPhaseAStart;
    timing_reg[RegPhaseAYellow] = RstPhaseAYellow;
    timing_reg[RegPhaseBStart] = RstPhaseBStart;
    timing_reg[RegPhaseBYellow] = RstPhaseBYellow;
    timing_reg[RegTransStart] = RstTransStart;
    timing_reg[RegSouthStart] = RstSouthStart;
    timing_reg[RegWestStart] = RstWestStart;
    light_phase = PhRoadOne;
    countdown = RstPhaseAStart;
    held_direction = 1'b0;
    countdown_loaded = 1'b0;
  endfunction

  function automatic res_t predict_lamps(input logic req, input logic dir);
    res_t lamps;
    logic [CountW-1:0] first;
    lamps = '0;
    if ((light_phase == PhRoadOne || light_phase == PhRoadTwo) && req) begin
      light_phase = PhTransition;
      held_direction = dir;
      countdown_loaded = 1'b0;
    end else if (light_phase == PhManualGreen && !req) begin
      light_phase = PhRoadOne;
      countdown_loaded = 1'b0;
    end
    if (!countdown_loaded) begin
      case (light_phase)
        PhRoadOne: first = timing_reg[RegPhaseAStart];
        PhRoadTwo: first = timing_reg[RegPhaseBStart];
        PhTransition: first = timing_reg[RegTransStart];
        default: first = held_direction ? timing_reg[RegWestStart] : timing_reg[RegSouthStart];
      endcase
      countdown = (first > 7'd99) ? 7'd99 : first;
      countdown_loaded = 1'b1;
    end
    case (light_phase)
      PhRoadOne: begin
        lamps.road_one_yellow = countdown > timing_reg[RegPhaseAYellow];
        lamps.road_one_green = !(countdown > timing_reg[RegPhaseAYellow]);
        lamps.road_two_red = 1'b1;
      end
      PhRoadTwo: begin
        lamps.road_one_red = 1'b1;
        lamps.road_two_yellow = countdown > timing_reg[RegPhaseBYellow];
        lamps.road_two_green = !(countdown > timing_reg[RegPhaseBYellow]);
      end
      PhTransition: begin
        lamps.road_one_yellow = 1'b1;
        lamps.road_two_yellow = 1'b1;
      end
      default: begin
        lamps.road_one_green = held_direction;
        lamps.road_two_red = held_direction;
        lamps.road_one_red = !held_direction;
        lamps.road_two_green = !held_direction;
      end
    endcase
    lamps.tens_digit = DigitW'(countdown / 10);
    lamps.units_digit = DigitW'(countdown % 10);
    if (countdown == '0) begin
      case (light_phase)
        PhRoadOne: light_phase = PhRoadTwo;
        PhTransition: light_phase = PhManualGreen;
        default: light_phase = PhRoadOne;
      endcase
      countdown_loaded = 1'b0;
    end else begin
      countdown = countdown - 1'b1;
    end
    return lamps;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 100) begin
      $display("mismatch at beat %0d: %s got %0d want %0d", beats_seen, what, got, want);
    end
  endtask

  task automatic check_field(input string what, input int got, input int want);
    if (got != want) begin
      report_mismatch(what, got, want);
    end
  endtask

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (lamp_queue.size() == 0) begin
        report_mismatch("unexpected beat, lamps", {road_one_red_o, road_one_yellow_o,
                        road_one_green_o, road_two_red_o, road_two_yellow_o,
                        road_two_green_o}, 0);
      end else begin
        want = lamp_queue.pop_front();
        check_field("road_one_red", road_one_red_o, want.road_one_red);
        check_field("road_one_yellow", road_one_yellow_o, want.road_one_yellow);
        check_field("road_one_green", road_one_green_o, want.road_one_green);
        check_field("road_two_red", road_two_red_o, want.road_two_red);
        check_field("road_two_yellow", road_two_yellow_o, want.road_two_yellow);
        check_field("road_two_green", road_two_green_o, want.road_two_green);
        check_field("tens_digit", tens_digit_o, want.tens_digit);
        check_field("units_digit", units_digit_o, want.units_digit);
      end
      beats_seen++;
    end
  end

  initial begin : ready_driver
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = LongHold;
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin : watchdog
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("testbench: done, errors");
    $finish;
  end

  task automatic send_tick(input logic req, input logic dir);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    manual_request_i <= req;
    manual_direction_i <= dir;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    lamp_queue.push_back(predict_lamps(req, dir));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (lamp_queue.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input int unsigned idx, input logic [DataW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrW'(4 * idx);
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx < NumRegs) begin
      timing_reg[idx] = value[CountW-1:0];
    end
  endtask

  task automatic set_timing(input int a, input int ay, input int b, input int by,
                            input int t, input int s, input int w);
    write_reg(RegPhaseAStart, a);
    write_reg(RegPhaseAYellow, ay);
    write_reg(RegPhaseBStart, b);
    write_reg(RegPhaseBYellow, by);
    write_reg(RegTransStart, t);
    write_reg(RegSouthStart, s);
    write_reg(RegWestStart, w);
  endtask

  // Mostly automatic stretches and held manual requests, with some raw noise.
  task automatic run_traffic(input int unsigned n_ticks);
    int unsigned sent;
    int unsigned roll;
    int unsigned len;
    sent = 0;
    while (sent < n_ticks) begin
      roll = $urandom_range(0, 99);
      len = $urandom_range(1, 40);
      if (roll < 10) begin
        len = $urandom_range(1, 6);
      end
      repeat (len) begin
        if (roll < 60) begin
          send_tick(1'b0, 1'($urandom));
        end else if (roll < 90) begin
          send_tick(1'b1, 1'($urandom));
        end else begin
          send_tick(1'($urandom), 1'($urandom));
        end
      end
      if (roll >= 60 && roll < 90) begin
        send_tick(1'b0, 1'($urandom));
        len++;
      end
      sent += len;
    end
  endtask

  function automatic int rand_start();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) begin
      return $urandom_range(0, 12);
    end else if (roll < 92) begin
      return $urandom_range(13, 99);
    end
    return $urandom_range(100, 127);
  endfunction

  task automatic test_directed();
    repeat (3) send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    repeat (3) send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    repeat (3) send_tick(1'b0, 1'b1);
    wait_idle();
  endtask

  task automatic test_config_extremes();
    set_timing(0, 0, 0, 0, 0, 0, 0);
    run_traffic(40);
    wait_idle();
    set_timing(127, 127, 127, 99, 127, 127, 127);
    write_reg(IgnoredReg, 32'hFFFF_FFFF);
    repeat (150) send_tick(1'b0, 1'b0);
    run_traffic(60);
    wait_idle();
    set_timing(3, 1, 4, 2, 0, 2, 1);
    write_reg(RegPhaseBYellow, {25'h1FF_FFFF, 7'd3});
    repeat (20) send_tick(1'b1, 1'b0);
    repeat (20) send_tick(1'b1, 1'b1);
    run_traffic(40);
    wait_idle();
  endtask

  task automatic test_random_settings();
    repeat (5) begin
      idling_on = 1'($urandom);
      set_timing(rand_start(), rand_start(), rand_start(), rand_start(),
                 rand_start(), rand_start(), rand_start());
      run_traffic(190);
      wait_idle();
    end
    idling_on = 1'b1;
  endtask

  task automatic test_output_stall();
    set_timing(5, 2, 4, 1, 2, 6, 3);
    idling_on = 1'b0;
    long_hold_req = 1'b1;
    run_traffic(40);
    idling_on = 1'b1;
    wait_idle();
  endtask

  initial begin
    reset_predictor();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_extremes();
    test_random_settings();
    test_output_stall();
    if (mismatches == 0 && lamp_queue.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
